@@ src/arpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    // Table depth default
    localparam int DEF_TABLE_ENTRIES = 16;

    // APB address width and register bit (64-bit registers at 8*i)
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam int REG_SEL_BIT = 3;
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    // Action codes
    localparam logic [2:0] ACT_RESOLVE = 3'd0;
    localparam logic [2:0] ACT_FRAME   = 3'd1;
    localparam logic [2:0] ACT_GSEND   = 3'd2;
    localparam logic [2:0] ACT_GRECV   = 3'd3;
    localparam logic [2:0] ACT_DELETE  = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;

    // Received ARP opcodes
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    // Emitted frame opcodes
    localparam logic [1:0] OUT_OP_NONE    = 2'd0;
    localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
    localparam logic [1:0] OUT_OP_REPLY   = 2'd2;

    // Status codes
    localparam logic [2:0] STS_DONE    = 3'd0;
    localparam logic [2:0] STS_HIT     = 3'd1;
    localparam logic [2:0] STS_PENDING = 3'd2;
    localparam logic [2:0] STS_FULL    = 3'd3;
    localparam logic [2:0] STS_IGNORED = 3'd4;

    localparam logic [47:0] BCAST_MAC = {6{8'hff}};

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } seq_state_t;

    // Table write controls
    typedef struct packed {
        logic we;
        logic set_valid;
        logic clr_valid;
        logic clr_all;
    } tbl_wr_t;

    // One result item
    typedef struct packed {
        logic        emit_frame;
        logic [2:0]  status;
        logic [1:0]  out_opcode;
        logic [47:0] out_sender_mac;
        logic [31:0] out_sender_ip;
        logic [47:0] out_target_mac;
        logic [31:0] out_target_ip;
        logic [47:0] resolved_mac;
    } arpc_res_t;

endpackage

`default_nettype wire

@@ src/arpc_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arpc_table #(
    parameter int TABLE_ENTRIES = arpc_pkg::DEF_TABLE_ENTRIES,
    localparam int IW = $clog2(TABLE_ENTRIES)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // read port, data in the cycle after the address
    input  wire logic [IW-1:0]    rd_addr,
    output logic                  rd_valid,
    output logic [31:0]           rd_ip,
    output logic [47:0]           rd_mac,
    output logic                  rd_complete,
    // write port
    input  wire arpc_pkg::tbl_wr_t wr_ctrl,
    input  wire logic [IW-1:0]    wr_addr,
    input  wire logic [31:0]      wr_ip,
    input  wire logic [47:0]      wr_mac,
    input  wire logic             wr_complete
);
    import arpc_pkg::*;

    localparam int MW = 32 + 48 + 1;

    logic [MW-1:0]            mem [TABLE_ENTRIES];
    logic [MW-1:0]            rd_data_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;

    // Entry storage: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_ctrl.we)
        begin
            mem[wr_addr] <= {wr_ip, wr_mac, wr_complete};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid bits in flops, cleared by reset or clear-all, set or cleared per entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_ctrl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_ctrl.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (wr_ctrl.clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
        end
    end

    assign rd_valid    = rd_valid_reg;
    assign rd_ip       = rd_data_reg[MW-1 -: 32];
    assign rd_mac      = rd_data_reg[48:1];
    assign rd_complete = rd_data_reg[0];

endmodule

`default_nettype wire

@@ src/arpc_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arpc_seq #(
    parameter int TABLE_ENTRIES = arpc_pkg::DEF_TABLE_ENTRIES,
    localparam int IW = $clog2(TABLE_ENTRIES)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input item
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         action,
    input  wire logic [15:0]        frame_opcode,
    input  wire logic [47:0]        sender_mac,
    input  wire logic [31:0]        sender_ip,
    input  wire logic [31:0]        target_ip,
    // station addresses
    input  wire logic [31:0]        own_ip,
    input  wire logic [47:0]        own_mac,
    // table access
    output logic [IW-1:0]           rd_addr,
    input  wire logic               rd_valid,
    input  wire logic [31:0]        rd_ip,
    input  wire logic [47:0]        rd_mac,
    input  wire logic               rd_complete,
    output arpc_pkg::tbl_wr_t       wr_ctrl,
    output logic [IW-1:0]           wr_addr,
    output logic [31:0]             wr_ip,
    output logic [47:0]             wr_mac,
    output logic                    wr_complete,
    // result hand-off
    input  wire logic               slot_free,
    output logic                    push,
    output arpc_pkg::arpc_res_t     res
);
    import arpc_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    seq_state_t  state_reg, state_next;
    logic [IW-1:0] cnt_reg;
    logic        cmp_vld_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic [2:0]  act_reg;
    logic [15:0] opc_reg;
    logic [47:0] smac_reg;
    logic [31:0] sip_reg;
    logic [31:0] tip_reg;
    logic        hit_found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [47:0] hit_mac_reg;
    logic        hit_cmp_reg;
    logic        free_found_reg;
    logic [IW-1:0] free_idx_reg;

    logic        accept;
    logic        need_scan;
    logic [31:0] key;
    logic        key_match;
    tbl_wr_t     wr_dec;

    assign accept = in_valid && in_ready;

    // Only lookups and inserts walk the table
    always_comb
    begin
        need_scan = 1'b0;
        case (action)
            ACT_RESOLVE, ACT_GRECV, ACT_DELETE: need_scan = 1'b1;
            ACT_FRAME:                          need_scan = (frame_opcode == OPC_REPLY);
            default:                            need_scan = 1'b0;
        endcase
    end

    // Lookup key: target IP for resolve and delete, sender IP otherwise
    assign key = (act_reg == ACT_RESOLVE || act_reg == ACT_DELETE) ? tip_reg : sip_reg;

    // Shared compare unit, one entry per cycle
    assign key_match = rd_valid && (rd_ip == key);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_scan ? ST_SCAN : ST_DECIDE;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake and table controls
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_DECIDE: push     = slot_free;
            default:
            begin
                in_ready = 1'b0;
                push     = 1'b0;
            end
        endcase
        rd_addr = cnt_reg;
        wr_ctrl = push ? wr_dec : '0;
    end

    // Decision on the action and the scan outcome
    always_comb
    begin
        res         = '0;
        res.status  = STS_DONE;
        wr_dec      = '0;
        wr_addr     = hit_idx_reg;
        wr_ip       = key;
        wr_mac      = smac_reg;
        wr_complete = 1'b1;
        case (act_reg)
            ACT_RESOLVE:
            begin
                if (hit_found_reg)
                begin
                    if (hit_cmp_reg)
                    begin
                        res.status       = STS_HIT;
                        res.resolved_mac = hit_mac_reg;
                    end
                    else
                    begin
                        res.status = STS_PENDING;
                    end
                end
                else if (free_found_reg)
                begin
                    wr_dec.we          = 1'b1;
                    wr_dec.set_valid   = 1'b1;
                    wr_addr            = free_idx_reg;
                    wr_mac             = BCAST_MAC;
                    wr_complete        = 1'b0;
                    res.emit_frame     = 1'b1;
                    res.out_opcode     = OUT_OP_REQUEST;
                    res.out_sender_mac = own_mac;
                    res.out_sender_ip  = sip_reg;
                    res.out_target_mac = BCAST_MAC;
                    res.out_target_ip  = tip_reg;
                end
                else
                begin
                    res.status = STS_FULL;
                end
            end
            ACT_FRAME:
            begin
                if (opc_reg == OPC_REQUEST)
                begin
                    if (tip_reg == own_ip)
                    begin
                        res.emit_frame     = 1'b1;
                        res.out_opcode     = OUT_OP_REPLY;
                        res.out_sender_mac = own_mac;
                        res.out_sender_ip  = own_ip;
                        res.out_target_mac = smac_reg;
                        res.out_target_ip  = sip_reg;
                    end
                    else
                    begin
                        res.status = STS_IGNORED;
                    end
                end
                else if (opc_reg == OPC_REPLY && hit_found_reg)
                begin
                    wr_dec.we = 1'b1;
                end
                else
                begin
                    res.status = STS_IGNORED;
                end
            end
            ACT_GSEND:
            begin
                res.emit_frame     = 1'b1;
                res.out_opcode     = OUT_OP_REQUEST;
                res.out_sender_mac = own_mac;
                res.out_sender_ip  = own_ip;
                res.out_target_mac = BCAST_MAC;
                res.out_target_ip  = own_ip;
            end
            ACT_GRECV:
            begin
                if (hit_found_reg)
                begin
                    wr_dec.we = 1'b1;
                end
                else if (free_found_reg)
                begin
                    wr_dec.we        = 1'b1;
                    wr_dec.set_valid = 1'b1;
                    wr_addr          = free_idx_reg;
                end
                else
                begin
                    res.status = STS_FULL;
                end
            end
            ACT_DELETE:
            begin
                wr_dec.clr_valid = hit_found_reg;
            end
            ACT_CLEAR:
            begin
                wr_dec.clr_all = 1'b1;
            end
            default:
            begin
                res.status = STS_IGNORED;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (accept)
            begin
                cnt_reg        <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (cmp_vld_reg && key_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (cmp_vld_reg && !rd_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // Item and scan payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cnt_reg;
        if (accept)
        begin
            act_reg  <= action;
            opc_reg  <= frame_opcode;
            smac_reg <= sender_mac;
            sip_reg  <= sender_ip;
            tip_reg  <= target_ip;
        end
        if (cmp_vld_reg && key_match && !hit_found_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_mac_reg <= rd_mac;
            hit_cmp_reg <= rd_complete;
        end
        if (cmp_vld_reg && !rd_valid && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after taking an item");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> slot_free)
        else $error("result pushed into a full output slot");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("compare outside of a table scan");

    a_insert_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctrl.set_valid |-> (!hit_found_reg && free_found_reg))
        else $error("new entry inserted although key is present or table full");

endmodule

`default_nettype wire

@@ src/arp_cache_responder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// ARP cache and responder. Each input item is one action: resolve, received
// frame, gratuitous send, gratuitous receive, delete or clear all; each gives
// exactly one result item, which may carry an ARP frame to send. Actions that
// search the cache (resolve, reply frames, gratuitous receive, delete) walk
// the entry memory one entry per cycle through a single comparator, then pass
// a drain step before the decide step in which the result register loads;
// the other actions go from acceptance straight to the decide step. A new
// item is taken only after the sequencer has returned to idle.
// A result still waiting in the output register holds the sequencer in its
// last step; the block takes the next item while the previous result waits.
// own_ip is at APB address 0x0 and own_mac at 0x8, on a 64-bit data bus.
// No clearing pass is needed after reset.
module arp_cache_responder #(
    parameter int TABLE_ENTRIES = arpc_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [arpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [arpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [arpc_pkg::APB_DATA_W-1:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] frame_opcode,
    input  wire logic [47:0] sender_mac,
    input  wire logic [31:0] sender_ip,
    input  wire logic [31:0] target_ip,
    // result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             emit_frame,
    output logic [2:0]       status,
    output logic [1:0]       out_opcode,
    output logic [47:0]      out_sender_mac,
    output logic [31:0]      out_sender_ip,
    output logic [47:0]      out_target_mac,
    output logic [31:0]      out_target_ip,
    output logic [47:0]      resolved_mac
);
    import arpc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic [31:0]   own_ip_reg;
    logic [47:0]   own_mac_reg;
    logic          out_valid_reg;
    arpc_res_t     res_reg;

    logic          cfg_wr;
    logic [IW-1:0] rd_addr;
    logic          rd_valid;
    logic [31:0]   rd_ip;
    logic [47:0]   rd_mac;
    logic          rd_complete;
    tbl_wr_t       wr_ctrl;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_ip;
    logic [47:0]   wr_mac;
    logic          wr_complete;
    logic          slot_free;
    logic          push;
    arpc_res_t     res;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[REG_SEL_BIT] == REG_OWN_MAC)
            begin
                own_mac_reg <= pwdata[47:0];
            end
            else
            begin
                own_ip_reg <= pwdata[31:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[REG_SEL_BIT] == REG_OWN_MAC)
        begin
            prdata = {16'd0, own_mac_reg};
        end
        else
        begin
            prdata = {32'd0, own_ip_reg};
        end
    end

    // Cache storage
    arpc_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_addr     (rd_addr),
        .rd_valid    (rd_valid),
        .rd_ip       (rd_ip),
        .rd_mac      (rd_mac),
        .rd_complete (rd_complete),
        .wr_ctrl     (wr_ctrl),
        .wr_addr     (wr_addr),
        .wr_ip       (wr_ip),
        .wr_mac      (wr_mac),
        .wr_complete (wr_complete)
    );

    // Scan sequencer and action decode
    arpc_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .frame_opcode (frame_opcode),
        .sender_mac   (sender_mac),
        .sender_ip    (sender_ip),
        .target_ip    (target_ip),
        .own_ip       (own_ip_reg),
        .own_mac      (own_mac_reg),
        .rd_addr      (rd_addr),
        .rd_valid     (rd_valid),
        .rd_ip        (rd_ip),
        .rd_mac       (rd_mac),
        .rd_complete  (rd_complete),
        .wr_ctrl      (wr_ctrl),
        .wr_addr      (wr_addr),
        .wr_ip        (wr_ip),
        .wr_mac       (wr_mac),
        .wr_complete  (wr_complete),
        .slot_free    (slot_free),
        .push         (push),
        .res          (res)
    );

    // Output register
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign emit_frame     = res_reg.emit_frame;
    assign status         = res_reg.status;
    assign out_opcode     = res_reg.out_opcode;
    assign out_sender_mac = res_reg.out_sender_mac;
    assign out_sender_ip  = res_reg.out_sender_ip;
    assign out_target_mac = res_reg.out_target_mac;
    assign out_target_ip  = res_reg.out_target_ip;
    assign resolved_mac   = res_reg.resolved_mac;

endmodule

`default_nettype wire

@@ verif/arp_cache_responder_tb.sv @@
`timescale 1ns / 1ps

module arp_cache_responder_tb;
    import arpc_pkg::*;

    localparam int NUM_ENTRIES = DEF_TABLE_ENTRIES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = NUM_ENTRIES + 12;
    localparam int POOL_SIZE = 48;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 255;

    // Action codes with no function in the block
    localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

    localparam logic [31:0] IP_A = 32'h0A00_0001;
    localparam logic [31:0] IP_B = 32'h0A00_0002;

    // One ARP event as presented to the block
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] opcode;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [31:0] tip;
    } arp_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  action = '0;
    logic [15:0] frame_opcode = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] target_ip = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        emit_frame;
    logic [2:0]  status;
    logic [1:0]  out_opcode;
    logic [47:0] out_sender_mac;
    logic [31:0] out_sender_ip;
    logic [47:0] out_target_mac;
    logic [31:0] out_target_ip;
    logic [47:0] resolved_mac;

    arp_cache_responder #(
        .TABLE_ENTRIES(NUM_ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .frame_opcode(frame_opcode),
        .sender_mac(sender_mac),
        .sender_ip(sender_ip),
        .target_ip(target_ip),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .emit_frame(emit_frame),
        .status(status),
        .out_opcode(out_opcode),
        .out_sender_mac(out_sender_mac),
        .out_sender_ip(out_sender_ip),
        .out_target_mac(out_target_mac),
        .out_target_ip(out_target_ip),
        .resolved_mac(resolved_mac)
    );

    always #5 clk = ~clk;

    // Shadow cache and station addresses
    logic        cache_valid [NUM_ENTRIES];
    logic [31:0] cache_ip    [NUM_ENTRIES];
    logic [47:0] cache_mac   [NUM_ENTRIES];
    logic        cache_done  [NUM_ENTRIES];
    logic [31:0] cfg_ip = '0;
    logic [47:0] cfg_mac = '0;

    arp_event_t arp_events[$];
    arpc_res_t  predicted_results[$];
    logic [31:0] ip_pool [POOL_SIZE];

    int  fail_count = 0;
    int  queued_events = 0;
    int  cycle_count = 0;
    int  cfg_settings = 0;
    int  emit_count = 0;
    int  act_count [8];
    int  sts_count [8];
    bit  no_idle = 1'b0;

    function automatic int find_entry(logic [31:0] ip);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (cache_valid[i] && cache_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (!cache_valid[i])
                return i;
        return -1;
    endfunction

    // Insert or update; 0 when a new slot is needed and the table is full
    function automatic bit cache_store(logic [31:0] ip, logic [47:0] mac, logic done);
        int idx;
        idx = find_entry(ip);
        if (idx < 0)
        begin
            idx = first_free();
            if (idx < 0)
                return 1'b0;
            cache_valid[idx] = 1'b1;
            cache_ip[idx] = ip;
        end
        cache_mac[idx] = mac;
        cache_done[idx] = done;
        return 1'b1;
    endfunction

    function automatic arpc_res_t frame_result(logic [1:0] op, logic [47:0] smac,
                                               logic [31:0] sip, logic [47:0] tmac,
                                               logic [31:0] tip);
        arpc_res_t r;
        r = '0;
        r.emit_frame = 1'b1;
        r.status = STS_DONE;
        r.out_opcode = op;
        r.out_sender_mac = smac;
        r.out_sender_ip = sip;
        r.out_target_mac = tmac;
        r.out_target_ip = tip;
        return r;
    endfunction

    // Expected result of one event; updates the shadow cache
    function automatic arpc_res_t arp_predict(arp_event_t ev);
        arpc_res_t r;
        int idx;
        r = '0;
        r.status = STS_DONE;
        case (ev.action)
            ACT_RESOLVE:
            begin
                idx = find_entry(ev.tip);
                if (idx >= 0)
                begin
                    if (cache_done[idx])
                    begin
                        r.status = STS_HIT;
                        r.resolved_mac = cache_mac[idx];
                    end
                    else
                        r.status = STS_PENDING;
                end
                else if (!cache_store(ev.tip, BCAST_MAC, 1'b0))
                    r.status = STS_FULL;
                else
                    r = frame_result(OUT_OP_REQUEST, cfg_mac, ev.sip, BCAST_MAC, ev.tip);
            end
            ACT_FRAME:
            begin
                if (ev.opcode == OPC_REQUEST)
                begin
                    if (ev.tip == cfg_ip)
                        r = frame_result(OUT_OP_REPLY, cfg_mac, cfg_ip, ev.smac, ev.sip);
                    else
                        r.status = STS_IGNORED;
                end
                else if (ev.opcode == OPC_REPLY)
                begin
                    idx = find_entry(ev.sip);
                    if (idx >= 0)
                    begin
                        cache_mac[idx] = ev.smac;
                        cache_done[idx] = 1'b1;
                    end
                    else
                        r.status = STS_IGNORED;
                end
                else
                    r.status = STS_IGNORED;
            end
            ACT_GSEND:
                r = frame_result(OUT_OP_REQUEST, cfg_mac, cfg_ip, BCAST_MAC, cfg_ip);
            ACT_GRECV:
                if (!cache_store(ev.sip, ev.smac, 1'b1))
                    r.status = STS_FULL;
            ACT_DELETE:
            begin
                idx = find_entry(ev.tip);
                if (idx >= 0)
                    cache_valid[idx] = 1'b0;
            end
            ACT_CLEAR:
                for (int i = 0; i < NUM_ENTRIES; i++)
                    cache_valid[i] = 1'b0;
            default:
                r.status = STS_IGNORED;
        endcase
        return r;
    endfunction

    function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [31:0] pool_ip(int pool_n);
        return ip_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    function automatic logic [15:0] rand_opc();
        return 16'($urandom);
    endfunction

    function automatic void push_event(logic [2:0] act, logic [15:0] opc, logic [47:0] smac,
                                       logic [31:0] sip, logic [31:0] tip);
        arp_event_t ev;
        ev.action = act;
        ev.opcode = opc;
        ev.smac = smac;
        ev.sip = sip;
        ev.tip = tip;
        arp_events = {arp_events, ev};
        queued_events++;
    endfunction

    // Random traffic: mostly resolve/reply exchanges over a small address pool
    function automatic void queue_traffic(int count, int pool_n, bit allow_clear);
        int start;
        int pick;
        logic [31:0] ip;
        logic [2:0] act;
        start = queued_events;
        while (queued_events - start < count)
        begin
            pick = $urandom_range(0, 99);
            ip = pool_ip(pool_n);
            if (pick < 35)
            begin
                push_event(ACT_RESOLVE, rand_opc(), rand_mac(), $urandom, ip);
                if ($urandom_range(0, 1))
                    push_event(ACT_RESOLVE, rand_opc(), rand_mac(), $urandom, ip);
                push_event(ACT_FRAME, OPC_REPLY, rand_mac(), ip, $urandom);
                if ($urandom_range(0, 3) != 0)
                    push_event(ACT_RESOLVE, rand_opc(), rand_mac(), $urandom, ip);
            end
            else if (pick < 50)
                push_event(ACT_FRAME, OPC_REQUEST, rand_mac(), $urandom,
                           $urandom_range(0, 3) != 0 ? cfg_ip : ip);
            else if (pick < 62)
                push_event(ACT_GRECV, rand_opc(), rand_mac(), ip, $urandom);
            else if (pick < 70)
                push_event(ACT_DELETE, rand_opc(), rand_mac(), $urandom, ip);
            else if (pick < 75)
                push_event(ACT_GSEND, rand_opc(), rand_mac(), $urandom, $urandom);
            else if (pick < 78)
                push_event(ACT_FRAME, OPC_REPLY, rand_mac(), ip, $urandom);
            else if (pick < 80 && allow_clear)
                push_event(ACT_CLEAR, rand_opc(), rand_mac(), $urandom, $urandom);
            else if (pick < 85)
                push_event(ACT_RESOLVE, rand_opc(), rand_mac(), $urandom, ip);
            else
            begin
                // noise: any code, any field
                act = 3'($urandom_range(0, 7));
                if (act == ACT_CLEAR && !allow_clear)
                    act = ACT_UNUSED_7;
                push_event(act, $urandom_range(0, 1) ? rand_opc() : 16'($urandom_range(0, 3)),
                           rand_mac(), $urandom, $urandom_range(0, 1) ? $urandom : ip);
            end
        end
    endfunction

    // Register write, only while the block is idle
    task automatic cfg_write(input logic reg_sel, input logic [63:0] value);
        logic [APB_ADDR_W-1:0] addr;
        addr = '0;
        addr[REG_SEL_BIT] = reg_sel;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_OWN_IP)
            cfg_ip = value[31:0];
        else
            cfg_mac = value[47:0];
    endtask

    // Sample at the falling edge, after all updates of the rising edge
    task automatic wait_idle();
        do
            @(negedge clk);
        while (arp_events.size() != 0 || in_valid || predicted_results.size() != 0);
    endtask

    // Item driver
    arp_event_t cur_event;
    arpc_res_t  drv_pred;
    logic       drv_next_valid;
    int         gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            drv_next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                drv_pred = arp_predict(cur_event);
                predicted_results = {predicted_results, drv_pred};
                act_count[cur_event.action]++;
                sts_count[drv_pred.status]++;
                if (drv_pred.emit_frame)
                    emit_count++;
                drv_next_valid = 1'b0;
            end
            if (!drv_next_valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (arp_events.size() > 0)
                begin
                    cur_event = arp_events.pop_front();
                    action <= cur_event.action;
                    frame_opcode <= cur_event.opcode;
                    sender_mac <= cur_event.smac;
                    sender_ip <= cur_event.sip;
                    target_ip <= cur_event.tip;
                    drv_next_valid = 1'b1;
                    gap_left <= no_idle ? 0 : $urandom_range(0, 3);
                end
            end
            in_valid <= drv_next_valid;
        end
    end

    // Result monitor
    arpc_res_t mon_got;
    arpc_res_t mon_want;
    int        stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                mon_got = {emit_frame, status, out_opcode, out_sender_mac, out_sender_ip,
                           out_target_mac, out_target_ip, resolved_mac};
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result with none expected: expected nothing, actual %h",
                             $time, mon_got);
                    fail_count++;
                end
                else
                begin
                    mon_want = predicted_results.pop_front();
                    field_check("emit_frame", mon_want.emit_frame, mon_got.emit_frame);
                    field_check("status", mon_want.status, mon_got.status);
                    field_check("out_opcode", mon_want.out_opcode, mon_got.out_opcode);
                    field_check("out_sender_mac", mon_want.out_sender_mac,
                                mon_got.out_sender_mac);
                    field_check("out_sender_ip", mon_want.out_sender_ip, mon_got.out_sender_ip);
                    field_check("out_target_mac", mon_want.out_target_mac,
                                mon_got.out_target_mac);
                    field_check("out_target_ip", mon_want.out_target_ip, mon_got.out_target_ip);
                    field_check("resolved_mac", mon_want.resolved_mac, mon_got.resolved_mac);
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, predicted_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_ip[i] = '0;
            cache_mac[i] = '0;
            cache_done[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
        begin
            act_count[i] = 0;
            sts_count[i] = 0;
        end
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset addresses (own IP 0, own MAC 0)
        push_event(ACT_GSEND, 16'h0, 48'h0, 32'h0, 32'h0);
        push_event(ACT_RESOLVE, 16'h0, 48'h0, 32'hFFFF_FFFF, IP_A);        // miss
        push_event(ACT_RESOLVE, 16'hFFFF, BCAST_MAC, 32'h0, IP_A);         // pending
        push_event(ACT_FRAME, OPC_REPLY, BCAST_MAC, IP_A, 32'h0);          // completes
        push_event(ACT_RESOLVE, 16'h0, 48'h0, 32'h0, IP_A);                // hit
        push_event(ACT_FRAME, OPC_REPLY, 48'h0, IP_B, 32'h0);              // no entry
        push_event(ACT_FRAME, OPC_REQUEST, 48'h0123_4567_89AB, 32'hFFFF_FFFF, 32'h0);
        push_event(ACT_FRAME, OPC_REQUEST, BCAST_MAC, 32'h0, IP_A);        // not ours
        push_event(ACT_FRAME, 16'h0000, BCAST_MAC, IP_A, 32'h0);
        push_event(ACT_FRAME, 16'hFFFF, BCAST_MAC, IP_A, 32'h0);
        push_event(ACT_GRECV, 16'h0, 48'h0, 32'h0, 32'hFFFF_FFFF);         // insert
        push_event(ACT_GRECV, 16'h0, BCAST_MAC, 32'h0, 32'h0);             // update
        push_event(ACT_RESOLVE, 16'h0, 48'h0, 32'h0, 32'h0);               // hit
        push_event(ACT_DELETE, 16'h0, 48'h0, 32'h0, 32'h0);
        push_event(ACT_DELETE, 16'h0, 48'h0, 32'h0, 32'h0);                // absent
        push_event(ACT_RESOLVE, 16'h0, 48'h0, 32'h0, 32'h0);               // miss again
        push_event(ACT_UNUSED_6, OPC_REQUEST, BCAST_MAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_event(ACT_UNUSED_7, OPC_REPLY, BCAST_MAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_event(ACT_CLEAR, 16'h0, 48'h0, 32'h0, 32'h0);
        push_event(ACT_RESOLVE, 16'h0, 48'h0, 32'h0, IP_A);                // miss after clear

        // Random phases, each after a full drain and new addresses
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                1:
                begin
                    cfg_write(REG_OWN_IP, 64'hFFFF_FFFF);
                    cfg_write(REG_OWN_MAC, {16'h0, BCAST_MAC});
                end
                2:
                begin
                    cfg_write(REG_OWN_IP, 64'h0);
                    cfg_write(REG_OWN_MAC, 64'h0);
                end
                default:
                begin
                    cfg_write(REG_OWN_IP, {32'h0, $urandom});
                    cfg_write(REG_OWN_MAC, {16'h0, rand_mac()});
                end
            endcase
            cfg_settings++;
            @(negedge clk);
            no_idle = (ph == 3);
            // wide pool without clears fills the table
            if (ph == 4)
                queue_traffic(PHASE_ITEMS, POOL_SIZE, 1'b0);
            else
                queue_traffic(PHASE_ITEMS, (ph % 2) ? 12 : 24, 1'b1);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived: expected %0d more, actual 0", $time,
                     predicted_results.size(), predicted_results.size());
            fail_count++;
        end

        $display("Ran %0d events: resolve %0d, frame %0d, grat send %0d, grat recv %0d, delete %0d, clear %0d, unused %0d",
                 queued_events, act_count[ACT_RESOLVE], act_count[ACT_FRAME],
                 act_count[ACT_GSEND], act_count[ACT_GRECV], act_count[ACT_DELETE],
                 act_count[ACT_CLEAR], act_count[ACT_UNUSED_6] + act_count[ACT_UNUSED_7]);
        $display("Saw %0d hits, %0d pending, %0d table full, %0d ignored, %0d frames sent, %0d address settings, %0d errors",
                 sts_count[STS_HIT], sts_count[STS_PENDING], sts_count[STS_FULL],
                 sts_count[STS_IGNORED], emit_count, cfg_settings + 1, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ arp_cache_responder.f @@
src/arpc_pkg.sv
src/arpc_table.sv
src/arpc_seq.sv
src/arp_cache_responder.sv
verif/arp_cache_responder_tb.sv
